FILE: sv/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants for the PID controller with integral clamping.
// ----------------------------------------------------------------------------
package pidc_pkg;

    localparam int MUL_A_W = 51;
    localparam int MUL_B_W = 34;
    localparam int MUL_R_W = 52;
    localparam int DIV_N_W = 50;
    localparam int DIV_D_W = 32;

    localparam logic [1:0] MOP_P    = 2'd0;
    localparam logic [1:0] MOP_ERR  = 2'd1;
    localparam logic [1:0] MOP_ITRM = 2'd2;
    localparam logic [1:0] MOP_D    = 2'd3;

    localparam logic DOP_BACK  = 1'b0;
    localparam logic DOP_DERIV = 1'b1;

    localparam logic [2:0] REG_KP    = 3'd0;
    localparam logic [2:0] REG_KI    = 3'd1;
    localparam logic [2:0] REG_KD    = 3'd2;
    localparam logic [2:0] REG_UPPER = 3'd3;
    localparam logic [2:0] REG_LOWER = 3'd4;
    localparam logic [2:0] REG_TGT   = 3'd5;

    typedef struct packed {
        logic       load;
        logic       mul_go;
        logic [1:0] mul_op;
        logic       take_mul;
        logic       div_go;
        logic       div_op;
        logic       take_div;
        logic       d_zero;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic i_bound;
        logic ki_zero;
        logic dt_zero;
        logic out_full;
    } sts_t;

endpackage

FILE: sv/pid_controller_antiwindup_top.sv
// ----------------------------------------------------------------------------
// pid_controller_antiwindup_top
// PID controller, signed Q16.16, with integral clamping anti-windup.
// ----------------------------------------------------------------------------
// One request in, one result out. The time a step takes is set by two shared
// units. The multiplier runs three or four times. The one-bit-per-cycle 50-bit
// divider runs for the integral back-computation, for the derivative unless
// the time step is zero, for both or for neither. A new request is taken once
// the previous step has moved its result into the output register. A full
// output register holds the step in its last state.
module pid_controller_antiwindup_top
    import pidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // measured[31:0], time_step[55:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // drive[31:0]
    output logic        m_axis_tuser    // clamped
);

    cmd_t cmd;
    sts_t sts;

    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pidc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .in_data     (s_axis_tdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_drive   (m_axis_tdata),
        .out_clamped (m_axis_tuser)
    );

endmodule

FILE: sv/pidc_mul.sv
// ----------------------------------------------------------------------------
// pidc_mul
// Q.16 multiply, truncated, magnitude saturated at 2^50; done is raised after
// the LO, HI and FIN phases that follow start.
// ----------------------------------------------------------------------------
module pidc_mul
    import pidc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic                      done,
    output logic signed [MUL_R_W-1:0] res
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_FIN  = 2'd3;

    logic [1:0]  ph_reg, ph_next;
    logic [50:0] ua_reg;
    logic [32:0] ub_reg;
    logic        neg_reg;
    logic [64:0] lo_reg;
    logic [51:0] hp_reg;
    logic        done_reg;
    logic signed [MUL_R_W-1:0] res_reg;
    logic [50:0] m_sum, m_sat;
    logic [MUL_A_W-1:0] a_mag;
    logic [MUL_B_W-1:0] b_mag;

    assign a_mag = a[MUL_A_W-1] ? -a : a;
    assign b_mag = b[MUL_B_W-1] ? -b : b;
    assign m_sum = {1'b0, hp_reg[33:0], 16'd0} + {2'd0, lo_reg[64:16]};

    always_comb
    begin
        if (|hp_reg[51:34])
            m_sat = 51'd1 << 50;
        else if (m_sum > (51'd1 << 50))
            m_sat = 51'd1 << 50;
        else
            m_sat = m_sum;
    end

    always_comb
    begin
        unique case (ph_reg)
            PH_IDLE: ph_next = start ? PH_LO : PH_IDLE;
            PH_LO:   ph_next = PH_HI;
            PH_HI:   ph_next = PH_FIN;
            PH_FIN:  ph_next = PH_IDLE;
            default: ph_next = PH_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            ph_reg   <= ph_next;
            done_reg <= (ph_reg == PH_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_reg == PH_IDLE && start)
        begin
            ua_reg  <= a_mag;
            ub_reg  <= b_mag[32:0];
            neg_reg <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
        end
        if (ph_reg == PH_LO)
            lo_reg <= {33'd0, ua_reg[31:0]} * {32'd0, ub_reg};
        if (ph_reg == PH_HI)
            hp_reg <= {33'd0, ua_reg[50:32]} * {19'd0, ub_reg};
        if (ph_reg == PH_FIN)
            res_reg <= neg_reg ? -$signed({1'b0, m_sat}) : $signed({1'b0, m_sat});
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: sv/pidc_div.sv
// ----------------------------------------------------------------------------
// pidc_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidc_div
    import pidc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] num,
    input  logic [DIV_D_W-1:0] den,
    output logic               done,
    output logic [DIV_N_W-1:0] quot
);

    logic               busy_reg;
    logic [5:0]         cnt_reg;
    logic               done_reg;
    logic [DIV_N_W-1:0] q_reg;
    logic [DIV_D_W-1:0] den_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W:0]   trial;
    logic               fits;

    assign trial = {rem_reg, q_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg && start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_N_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy_reg && start)
        begin
            q_reg   <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIV_D_W'(trial - {1'b0, den_reg}) : trial[DIV_D_W-1:0];
            q_reg   <= {q_reg[DIV_N_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: sv/pidc_dp.sv
// ----------------------------------------------------------------------------
// pidc_dp
// Datapath: gain and limit registers, loop state, shared multiply and divide.
// ----------------------------------------------------------------------------
module pidc_dp
    import pidc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    input  logic [55:0] in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_drive,
    output logic        out_clamped
);

    logic signed [31:0] kp_reg, ki_reg, kd_reg, upper_reg, lower_reg, tgt_reg;
    logic signed [47:0] acc_reg;
    logic signed [32:0] last_err_reg, err_reg;
    logic [23:0]        dt_reg;
    logic signed [51:0] p_reg, d_reg;
    logic signed [31:0] i_reg;
    logic               bound_reg;
    logic               bound_up_reg;
    logic signed [50:0] q_reg;
    logic               ov_reg;
    logic [31:0]        drive_reg;
    logic               clamp_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic                      mul_done;
    logic signed [MUL_R_W-1:0] mul_res;
    logic [DIV_N_W-1:0]        div_num;
    logic [DIV_D_W-1:0]        div_den;
    logic                      div_done;
    logic [DIV_N_W-1:0]        div_q;

    logic signed [32:0] err_new;
    logic signed [33:0] diff;
    logic [33:0]        diff_mag;
    logic signed [31:0] lim;
    logic [31:0]        lim_mag, ki_mag;
    logic               back_neg;
    logic signed [52:0] acc_sum;
    logic signed [47:0] acc_sat;
    logic signed [47:0] back_val;
    logic signed [53:0] sum, sum1;
    logic signed [51:0] up52, lo52;

    assign err_new  = 33'(tgt_reg) - 33'($signed(in_data[31:0]));
    assign diff     = 34'(err_reg) - 34'(last_err_reg);
    assign diff_mag = diff[33] ? 34'(-diff) : 34'(diff);
    assign lim      = bound_up_reg ? upper_reg : lower_reg;
    assign lim_mag  = lim[31] ? 32'(-lim) : 32'(lim);
    assign ki_mag   = ki_reg[31] ? 32'(-ki_reg) : 32'(ki_reg);
    assign back_neg = lim[31] ^ ki_reg[31];
    assign up52     = 52'(upper_reg);
    assign lo52     = 52'(lower_reg);

    always_comb
    begin
        case (cmd.mul_op)
            MOP_P:    begin mul_a = 51'(err_reg); mul_b = 34'(kp_reg); end
            MOP_ERR:  begin mul_a = 51'(err_reg); mul_b = $signed({10'd0, dt_reg}); end
            MOP_ITRM: begin mul_a = 51'(acc_reg); mul_b = 34'(ki_reg); end
            default:  begin mul_a = q_reg;        mul_b = 34'(kd_reg); end
        endcase
    end

    always_comb
    begin
        if (cmd.div_op == DOP_BACK)
        begin
            div_num = {2'd0, lim_mag, 16'd0};
            div_den = ki_mag;
        end
        else
        begin
            div_num = {diff_mag, 16'd0};
            div_den = {8'd0, dt_reg};
        end
    end

    always_comb
    begin
        acc_sum = 53'(acc_reg) + 53'(mul_res);
        if (acc_sum > 53'sd140737488355327)
            acc_sat = 48'sh7FFFFFFFFFFF;
        else if (acc_sum < -53'sd140737488355328)
            acc_sat = 48'sh800000000000;
        else
            acc_sat = acc_sum[47:0];
    end

    always_comb
    begin
        if (!back_neg)
            back_val = (div_q > 50'h7FFFFFFFFFFF) ? 48'sh7FFFFFFFFFFF : $signed(div_q[47:0]);
        else
            back_val = (div_q >= 50'h800000000000) ? 48'sh800000000000
                                                   : 48'(-$signed({1'b0, div_q[47:0]}));
    end

    assign sum  = 54'(p_reg) + 54'(i_reg) + 54'(d_reg);
    assign sum1 = (sum > 54'(upper_reg)) ? 54'(upper_reg) : sum;

    pidc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_go),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .res   (mul_res)
    );

    pidc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            upper_reg    <= 32'sh7FFFFFFF;
            lower_reg    <= 32'sh80000000;
            tgt_reg      <= '0;
            acc_reg      <= '0;
            last_err_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_KP:    kp_reg    <= wr_data;
                    REG_KI:    ki_reg    <= wr_data;
                    REG_KD:    kd_reg    <= wr_data;
                    REG_UPPER: upper_reg <= wr_data;
                    REG_LOWER: lower_reg <= wr_data;
                    REG_TGT:   tgt_reg   <= wr_data;
                    default:   ;
                endcase
            end
            if (cmd.take_mul && cmd.mul_op == MOP_ERR)
                acc_reg <= acc_sat;
            if (cmd.take_div && cmd.div_op == DOP_BACK)
                acc_reg <= back_val;
            if (cmd.fin)
            begin
                last_err_reg <= err_reg;
                ov_reg       <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= err_new;
            dt_reg  <= in_data[55:32];
        end
        if (cmd.take_mul)
        begin
            case (cmd.mul_op)
                MOP_P: p_reg <= mul_res;
                MOP_ITRM:
                begin
                    if (mul_res > up52)
                    begin
                        i_reg        <= upper_reg;
                        bound_reg    <= 1'b1;
                        bound_up_reg <= 1'b1;
                    end
                    else if (mul_res < lo52)
                    begin
                        i_reg        <= lower_reg;
                        bound_reg    <= 1'b1;
                        bound_up_reg <= 1'b0;
                    end
                    else
                    begin
                        i_reg        <= mul_res[31:0];
                        bound_reg    <= 1'b0;
                        bound_up_reg <= 1'b0;
                    end
                end
                MOP_D:   d_reg <= mul_res;
                default: ;
            endcase
        end
        if (cmd.take_div && cmd.div_op == DOP_DERIV)
            q_reg <= diff[33] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        if (cmd.d_zero)
            d_reg <= '0;
        if (cmd.fin)
        begin
            drive_reg <= (sum1 < 54'(lower_reg)) ? lower_reg : sum1[31:0];
            clamp_reg <= (sum > 54'(upper_reg)) || (sum1 < 54'(lower_reg));
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.div_done = div_done;
    assign sts.i_bound  = bound_reg;
    assign sts.ki_zero  = (ki_reg == '0);
    assign sts.dt_zero  = (dt_reg == '0);
    assign sts.out_full = ov_reg;

    assign out_valid   = ov_reg;
    assign out_drive   = drive_reg;
    assign out_clamped = clamp_reg;

endmodule

FILE: sv/pidc_ctrl.sv
// ----------------------------------------------------------------------------
// pidc_ctrl
// Sequencer: orders the multiplies and divides of one control step.
// ----------------------------------------------------------------------------
module pidc_ctrl
    import pidc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL_P = 4'd1;
    localparam logic [3:0] S_W_P   = 4'd2;
    localparam logic [3:0] S_MUL_E = 4'd3;
    localparam logic [3:0] S_W_E   = 4'd4;
    localparam logic [3:0] S_MUL_I = 4'd5;
    localparam logic [3:0] S_W_I   = 4'd6;
    localparam logic [3:0] S_CHK   = 4'd7;
    localparam logic [3:0] S_W_B   = 4'd8;
    localparam logic [3:0] S_DER   = 4'd9;
    localparam logic [3:0] S_W_Q   = 4'd10;
    localparam logic [3:0] S_MUL_D = 4'd11;
    localparam logic [3:0] S_W_D   = 4'd12;
    localparam logic [3:0] S_FIN   = 4'd13;

    logic [3:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL_P;
                end
            S_MUL_P:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MOP_P;
                state_next = S_W_P;
            end
            S_W_P:
            begin
                cmd.mul_op = MOP_P;
                if (sts.mul_done)
                begin
                    cmd.take_mul = 1'b1;
                    state_next   = S_MUL_E;
                end
            end
            S_MUL_E:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MOP_ERR;
                state_next = S_W_E;
            end
            S_W_E:
            begin
                cmd.mul_op = MOP_ERR;
                if (sts.mul_done)
                begin
                    cmd.take_mul = 1'b1;
                    state_next   = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MOP_ITRM;
                state_next = S_W_I;
            end
            S_W_I:
            begin
                cmd.mul_op = MOP_ITRM;
                if (sts.mul_done)
                begin
                    cmd.take_mul = 1'b1;
                    state_next   = S_CHK;
                end
            end
            S_CHK:
                if (sts.i_bound && !sts.ki_zero)
                begin
                    cmd.div_go = 1'b1;
                    cmd.div_op = DOP_BACK;
                    state_next = S_W_B;
                end
                else
                    state_next = S_DER;
            S_W_B:
            begin
                cmd.div_op = DOP_BACK;
                if (sts.div_done)
                begin
                    cmd.take_div = 1'b1;
                    state_next   = S_DER;
                end
            end
            S_DER:
                if (sts.dt_zero)
                begin
                    cmd.d_zero = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.div_go = 1'b1;
                    cmd.div_op = DOP_DERIV;
                    state_next = S_W_Q;
                end
            S_W_Q:
            begin
                cmd.div_op = DOP_DERIV;
                if (sts.div_done)
                begin
                    cmd.take_div = 1'b1;
                    state_next   = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                cmd.mul_go = 1'b1;
                cmd.mul_op = MOP_D;
                state_next = S_W_D;
            end
            S_W_D:
            begin
                cmd.mul_op = MOP_D;
                if (sts.mul_done)
                begin
                    cmd.take_mul = 1'b1;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
                if (!sts.out_full || out_ready)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
